@@ hdl/aosma_pkg.sv @@
// shared types, widths and register codes for the accel offset/scale moving average
`default_nettype none

package aosma_pkg;

  localparam int RAW_W      = 16;
  localparam int AVG_W      = 16;
  localparam int GAIN_W     = 20;
  localparam int DIFF_W     = RAW_W + 1;
  localparam int PROD_W     = DIFF_W + GAIN_W + 1;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam int WINDOW_DEPTH_DEF = 16;
  localparam int WINDOW_SHIFT_DEF = 4;

  localparam int AVG_MAX = 32767;
  localparam int AVG_MIN = -32768;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4000);
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRAC_W - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_OFFSET_Z = 3'd2,
    REG_GAIN     = 3'd3
  } reg_idx_t;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
  } sample_t;

  typedef struct packed {
    logic signed [AVG_W-1:0] avg_x;
    logic signed [AVG_W-1:0] avg_y;
    logic signed [AVG_W-1:0] avg_z;
  } result_t;

  typedef struct packed {
    logic load1;
    logic load2;
    logic load3;
    logic commit;
  } lane_ctl_t;

endpackage

`default_nettype wire

@@ hdl/aosma_lane.sv @@
// one axis lane: offset, gain, rounding, ring and running sum
`default_nettype none

module aosma_lane import aosma_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int WINDOW_SHIFT = WINDOW_SHIFT_DEF,
  localparam int SLOT_W = $clog2(WINDOW_DEPTH),
  localparam int SUM_W  = AVG_W + SLOT_W + 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire lane_ctl_t               ctl,
  input  wire logic [SLOT_W-1:0]       slot_rd,
  input  wire logic [SLOT_W-1:0]       slot_wr,
  input  wire logic signed [RAW_W-1:0] raw,
  input  wire logic signed [RAW_W-1:0] offset,
  input  wire logic [GAIN_W-1:0]       gain,
  output logic signed [AVG_W-1:0]      avg
);

  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] diff_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] scaled;
  logic signed [AVG_W-1:0]  cal;
  logic signed [AVG_W-1:0]  cal_next;
  logic signed [AVG_W-1:0]  old;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_next;
  logic signed [SUM_W-1:0]  shifted;
  logic signed [AVG_W-1:0]  ring [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]  filled;

  assign diff_next = DIFF_W'(raw) - DIFF_W'(offset);
  assign prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, gain}));

  // round half up, then clamp to 16 bits
  assign rounded = prod + ROUND_HALF;
  assign scaled  = rounded >>> FRAC_W;

  always_comb begin
    if (scaled > $signed(PROD_W'(AVG_MAX))) begin
      cal_next = AVG_W'(AVG_MAX);
    end else if (scaled < $signed(PROD_W'(AVG_MIN))) begin
      cal_next = AVG_W'(AVG_MIN);
    end else begin
      cal_next = scaled[AVG_W-1:0];
    end
  end

  assign sum_next = sum - SUM_W'(old) + SUM_W'(cal);
  assign shifted  = sum_next >>> WINDOW_SHIFT;

  always_comb begin
    if (shifted > $signed(SUM_W'(AVG_MAX))) begin
      avg = AVG_W'(AVG_MAX);
    end else if (shifted < $signed(SUM_W'(AVG_MIN))) begin
      avg = AVG_W'(AVG_MIN);
    end else begin
      avg = shifted[AVG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      diff <= diff_next;
    end
    if (ctl.load2) begin
      prod <= prod_next;
    end
    if (ctl.load3) begin
      cal <= cal_next;
      old <= filled[slot_rd] ? ring[slot_rd] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      ring[slot_wr] <= cal;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum    <= '0;
      filled <= '0;
    end else if (ctl.commit) begin
      sum             <= sum_next;
      filled[slot_wr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ hdl/aosma_ctrl.sv @@
// pipeline occupancy, handshake and ring slot tracking shared by the lanes
`default_nettype none

module aosma_ctrl import aosma_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  localparam int SLOT_W = $clog2(WINDOW_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  output logic                   sample_stall,
  input  wire logic              result_free,
  output lane_ctl_t              ctl,
  output logic [SLOT_W-1:0]      slot_rd,
  output logic [SLOT_W-1:0]      slot_wr
);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);

  logic              v1;
  logic              v2;
  logic              v3;
  logic              r1;
  logic              r2;
  logic              r3;
  logic [SLOT_W-1:0] slot0;
  logic [SLOT_W-1:0] slot0_next;
  logic [SLOT_W-1:0] slot1;
  logic [SLOT_W-1:0] slot2;
  logic [SLOT_W-1:0] slot3;

  // a stage takes a new request when empty or when it hands its own on
  assign r3 = !v3 || result_free;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;

  assign ctl.commit = v3 && result_free;
  assign ctl.load3  = v2 && r3;
  assign ctl.load2  = v1 && r2;
  assign ctl.load1  = sample_valid && r1;

  assign sample_stall = !r1;
  assign slot_rd      = slot2;
  assign slot_wr      = slot3;
  assign slot0_next   = (slot0 == SLOT_LAST) ? '0 : slot0 + SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      slot0 <= '0;
    end else begin
      if (ctl.load1) begin
        v1    <= 1'b1;
        slot0 <= slot0_next;
      end else if (ctl.load2) begin
        v1 <= 1'b0;
      end
      if (ctl.load2) begin
        v2 <= 1'b1;
      end else if (ctl.load3) begin
        v2 <= 1'b0;
      end
      if (ctl.load3) begin
        v3 <= 1'b1;
      end else if (ctl.commit) begin
        v3 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load1) begin
      slot1 <= slot0;
    end
    if (ctl.load2) begin
      slot2 <= slot1;
    end
    if (ctl.load3) begin
      slot3 <= slot2;
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot0 <= SLOT_LAST)
    else $error("write slot out of range");

  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    ctl.load1 |=> v1)
    else $error("accepted request lost in first stage");

  a_no_slot_clash: assert property (@(posedge clk) disable iff (rst)
    v2 && v3 |-> slot2 != slot3)
    else $error("ring read and write hit the same slot");

  a_hold_stage: assert property (@(posedge clk) disable iff (rst)
    v1 && !r2 |=> v1 && $stable(slot1))
    else $error("held stage changed");

endmodule

`default_nettype wire

@@ hdl/aosma_merge.sv @@
// merges the lane averages into the registered result request
`default_nettype none

module aosma_merge import aosma_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    commit,
  input  wire logic signed [AVG_W-1:0] avg_x,
  input  wire logic signed [AVG_W-1:0] avg_y,
  input  wire logic signed [AVG_W-1:0] avg_z,
  output logic                         result_free,
  output logic                         result_valid,
  input  wire logic                    result_stall,
  output result_t                      result
);

  assign result_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      result.avg_x <= avg_x;
      result.avg_y <= avg_y;
      result.avg_z <= avg_z;
    end
  end

endmodule

`default_nettype wire

@@ hdl/accel_offset_scale_moving_average.sv @@
// top level: accelerometer offset, gain and boxcar moving average
//
// sample channel: sample_valid / sample_stall carry one raw x/y/z request;
// it is taken at a clock edge with sample_valid high and sample_stall low
// result channel: result_valid / result_stall carry the windowed averages
// in milli-g; one result per sample, in order
// config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; writes
// are taken every cycle and belong only in idle periods
// throughput: one sample per cycle unless stalled; three axis lanes run side
// by side, each with one multiplier stage and a ring with one read and one
// write port; samples pass the diff, prod and cal registers into the result
// reset: offsets 0, gain 4000, running sums and ring valid bits cleared,
// no clearing pass is needed
// result stall: the result register holds, the three lane stages keep taking
// samples until they are all full, then sample_stall rises
`default_nettype none

module accel_offset_scale_moving_average import aosma_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int WINDOW_SHIFT = WINDOW_SHIFT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  sample_valid,
  output logic                       sample_stall,
  input  wire sample_t               sample,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SLOT_W = $clog2(WINDOW_DEPTH);

  logic signed [RAW_W-1:0]  offset_x;
  logic signed [RAW_W-1:0]  offset_y;
  logic signed [RAW_W-1:0]  offset_z;
  logic [GAIN_W-1:0]        gain_q16;
  lane_ctl_t                ctl;
  logic [SLOT_W-1:0]        slot_rd;
  logic [SLOT_W-1:0]        slot_wr;
  logic                     result_free;
  logic signed [AVG_W-1:0]  avg_x;
  logic signed [AVG_W-1:0]  avg_y;
  logic signed [AVG_W-1:0]  avg_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      gain_q16 <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_OFFSET_X: begin
          offset_x <= cfg_data[RAW_W-1:0];
        end
        REG_OFFSET_Y: begin
          offset_y <= cfg_data[RAW_W-1:0];
        end
        REG_OFFSET_Z: begin
          offset_z <= cfg_data[RAW_W-1:0];
        end
        REG_GAIN: begin
          gain_q16 <= cfg_data[GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  aosma_ctrl #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .result_free (result_free),
    .ctl         (ctl),
    .slot_rd     (slot_rd),
    .slot_wr     (slot_wr)
  );

  aosma_lane #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .WINDOW_SHIFT(WINDOW_SHIFT)
  ) u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .slot_rd(slot_rd),
    .slot_wr(slot_wr),
    .raw    (sample.raw_x),
    .offset (offset_x),
    .gain   (gain_q16),
    .avg    (avg_x)
  );

  aosma_lane #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .WINDOW_SHIFT(WINDOW_SHIFT)
  ) u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .slot_rd(slot_rd),
    .slot_wr(slot_wr),
    .raw    (sample.raw_y),
    .offset (offset_y),
    .gain   (gain_q16),
    .avg    (avg_y)
  );

  aosma_lane #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .WINDOW_SHIFT(WINDOW_SHIFT)
  ) u_lane_z (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .slot_rd(slot_rd),
    .slot_wr(slot_wr),
    .raw    (sample.raw_z),
    .offset (offset_z),
    .gain   (gain_q16),
    .avg    (avg_z)
  );

  aosma_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .commit      (ctl.commit),
    .avg_x       (avg_x),
    .avg_y       (avg_y),
    .avg_z       (avg_z),
    .result_free (result_free),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

`default_nettype wire

@@ sim/aosma_checker.sv @@
// checker for the accel offset/scale moving average: predicts window means and compares results
`timescale 1ns / 1ps

module aosma_checker import aosma_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int WINDOW_SHIFT = WINDOW_SHIFT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  input  logic                  sample_stall,
  input  sample_t               sample,
  input  logic                  result_valid,
  input  logic                  result_stall,
  input  result_t               result,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    pending
);

  logic signed [RAW_W-1:0] offs [3];
  logic [GAIN_W-1:0]       gain;
  logic signed [AVG_W-1:0] hist [3][WINDOW_DEPTH];
  longint                  acc [3];
  int                      slot;
  result_t                 avg_fifo [$];

  function automatic longint clamp16(input longint v);
    if (v > AVG_MAX) return AVG_MAX;
    if (v < AVG_MIN) return AVG_MIN;
    return v;
  endfunction

  function automatic logic signed [AVG_W-1:0] calibrate_axis(
    input logic signed [RAW_W-1:0] raw,
    input logic signed [RAW_W-1:0] ofs,
    input logic [GAIN_W-1:0]       g
  );
    longint prod;
    prod = (longint'(raw) - longint'(ofs)) * longint'(g);
    return AVG_W'(clamp16((prod + 64'sd32768) >>> FRAC_W));
  endfunction

  task automatic advance_window(input sample_t s, output result_t m);
    logic signed [RAW_W-1:0] raws [3];
    logic signed [AVG_W-1:0] means [3];
    logic signed [AVG_W-1:0] cal;
    raws[0] = s.raw_x;
    raws[1] = s.raw_y;
    raws[2] = s.raw_z;
    for (int a = 0; a < 3; a++) begin
      cal = calibrate_axis(raws[a], offs[a], gain);
      acc[a] = acc[a] - longint'(hist[a][slot]) + longint'(cal);
      hist[a][slot] = cal;
      means[a] = AVG_W'(clamp16(acc[a] >>> WINDOW_SHIFT));
    end
    slot = (slot + 1 >= WINDOW_DEPTH) ? 0 : slot + 1;
    m.avg_x = means[0];
    m.avg_y = means[1];
    m.avg_z = means[2];
  endtask

  function automatic int field_differs(
    input string name,
    input logic signed [AVG_W-1:0] want,
    input logic signed [AVG_W-1:0] got
  );
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        offs[a] = '0;
        acc[a]  = 0;
        for (int i = 0; i < WINDOW_DEPTH; i++) hist[a][i] = '0;
      end
      gain = GAIN_RESET;
      slot = 0;
      avg_fifo.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_OFFSET_X: offs[0] = cfg_data[RAW_W-1:0];
          REG_OFFSET_Y: offs[1] = cfg_data[RAW_W-1:0];
          REG_OFFSET_Z: offs[2] = cfg_data[RAW_W-1:0];
          REG_GAIN:     gain    = cfg_data[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (avg_fifo.size() == 0) begin
          $error("result with no request pending: avg_x %0d avg_y %0d avg_z %0d",
                 result.avg_x, result.avg_y, result.avg_z);
          mismatches++;
        end else begin
          want = avg_fifo.pop_front();
          mismatches += field_differs("avg_x", want.avg_x, result.avg_x);
          mismatches += field_differs("avg_y", want.avg_y, result.avg_y);
          mismatches += field_differs("avg_z", want.avg_z, result.avg_z);
        end
      end
      if (sample_valid && !sample_stall) begin
        advance_window(sample, want);
        avg_fifo.push_back(want);
      end
    end
    pending = avg_fifo.size();
  end

endmodule

@@ sim/tb.sv @@
// testbench top: drives samples, register writes and result stalls, then reports the verdict
`timescale 1ns / 1ps

module tb;
  import aosma_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 166;

  logic                  clk;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  sample_t               sample;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    pending;
  bit                    idle_on;
  int                    quiet_cycles;

  accel_offset_scale_moving_average u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  aosma_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic sample_t pack_raw(input logic [RAW_W-1:0] x, y, z);
    sample_t s;
    s.raw_x = x;
    s.raw_y = y;
    s.raw_z = z;
    return s;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 5))
      0: return RAW_W'($signed($urandom_range(0, 600)) - 300);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return RAW_W'($signed($urandom_range(0, 8000)) - 4000);
      default: return RAW_W'($urandom);
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_offset();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return RAW_W'($urandom);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return RAW_W'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 6))
      0: return GAIN_W'($urandom_range(0, 8191));
      1: return GAIN_W'($urandom_range(3000, 5000));
      2: return 20'hfffff;
      3: return 20'h10000;
      4: return '0;
      default: return GAIN_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input sample_t s);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_config(input logic [RAW_W-1:0] ox, oy, oz, input logic [GAIN_W-1:0] g);
    write_reg(REG_OFFSET_X, {4'($urandom), ox});
    write_reg(REG_OFFSET_Y, {4'($urandom), oy});
    write_reg(REG_OFFSET_Z, {4'($urandom), oz});
    write_reg(REG_GAIN, g);
    // unmapped index, must be ignored
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'(REG_GAIN) + CFG_IDX_W'($urandom_range(1, 4)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    idle_on      = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset gain, warm-up over a cleared window
    send_sample(pack_raw(16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_raw(16'h7fff, 16'h8000, 16'h0001));
    send_sample(pack_raw(16'h8000, 16'h7fff, 16'hffff));
    send_sample(pack_raw(16'h5555, 16'haaaa, 16'h0f0f));
    send_sample(pack_raw(16'hffff, 16'h0001, 16'h7fff));
    drain();

    // extreme offsets and full gain, saturation
    write_reg(REG_OFFSET_X, 20'ha8000);
    write_reg(REG_OFFSET_Y, 20'h57fff);
    write_reg(REG_OFFSET_Z, 20'hf0000);
    write_reg(REG_GAIN, 20'hfffff);
    write_reg(CFG_IDX_W'(REG_GAIN) + CFG_IDX_W'(1), 20'h12345);
    write_reg(CFG_IDX_W'(REG_GAIN) + CFG_IDX_W'(4), 20'hfffff);
    cfg_valid <= 1'b0;
    send_sample(pack_raw(16'h7fff, 16'h8000, 16'h7fff));
    send_sample(pack_raw(16'h8000, 16'h7fff, 16'h8000));
    send_sample(pack_raw(16'h0000, 16'h0000, 16'h0000));
    send_sample(pack_raw(16'h7fff, 16'h7fff, 16'h8000));
    send_sample(pack_raw(16'h0001, 16'hffff, 16'h0002));
    drain();

    // half milli-g per count, rounding ties upward
    apply_config(16'h0000, 16'h0000, 16'h0000, 20'h08000);
    send_sample(pack_raw(16'h0001, 16'hffff, 16'h0003));
    send_sample(pack_raw(16'hfffd, 16'h0000, 16'h0001));
    send_sample(pack_raw(16'hffff, 16'hffff, 16'hffff));
    drain();

    // zero gain
    apply_config(16'h1234, 16'hfedc, 16'h7fff, 20'h00000);
    send_sample(pack_raw(16'h7fff, 16'h8000, 16'h1234));
    send_sample(pack_raw(16'h0000, 16'h0000, 16'h0000));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      idle_on = (p != 3) && (p != PHASES - 1);
      apply_config(pick_offset(), pick_offset(), pick_offset(), pick_gain());
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_sample(pack_raw(pick_raw(), pick_raw(), pick_raw()));
      drain();
    end

    if (mismatches == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule

@@ sim.f @@
hdl/aosma_pkg.sv
hdl/aosma_lane.sv
hdl/aosma_ctrl.sv
hdl/aosma_merge.sv
hdl/accel_offset_scale_moving_average.sv
sim/aosma_checker.sv
sim/tb.sv
